### design/ccfd_pkg.sv
// ----------------------------------------------------------------------------
// ccfd_pkg
// shared types, constants and crc helpers of the crc checked frame deframer
// ----------------------------------------------------------------------------
package ccfd_pkg;

  // request codes
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CfgCrcEnable  = 2'd0;
  localparam logic [1:0] CfgHeaderSeed = 2'd1;
  localparam logic [1:0] CfgFrameSeed  = 2'd2;

  localparam logic        CrcEnableReset  = 1'b1;
  localparam logic [7:0]  HeaderSeedReset = 8'h77;
  localparam logic [15:0] FrameSeedReset  = 16'h3692;

  localparam logic [7:0]  SofByte   = 8'h55;
  localparam logic [9:0]  MinFrame  = 10'd13;
  localparam logic [7:0]  Crc8Poly  = 8'h8C;
  localparam logic [15:0] Crc16Poly = 16'h8408;

  // last header byte captured during the header pass
  localparam int unsigned HdrLast = 10;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  frame_length;
    logic [5:0]  protocol_version;
    logic [4:0]  sender_id;
    logic [2:0]  sender_index;
    logic [4:0]  receiver_id;
    logic [2:0]  receiver_index;
    logic [15:0] sequence_number;
    logic [7:0]  frame_flags;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
  } desc_t;

  typedef struct packed {
    logic        frame_valid;
    logic [9:0]  frame_length;
    logic [5:0]  protocol_version;
    logic [4:0]  sender_id;
    logic [2:0]  sender_index;
    logic [4:0]  receiver_id;
    logic [2:0]  receiver_index;
    logic [15:0] sequence_number;
    logic [7:0]  frame_flags;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic        queue_overflowed;
  } out_item_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ Crc8Poly) : (c >> 1);
    end
    return c;
  endfunction

  // reflected crc-16, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/crc_checked_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// byte stream deframer with start byte, length, crc-8 header and crc-16 frame
// checks, holding buffer in ram and a descriptor queue in ram
// ----------------------------------------------------------------------------
//  channel | signals                            | direction
//  in      | in_valid_i / in_ready_o / in_data_i  | push byte or pop request
//  out     | out_valid_o / out_ready_i / out_data_o | one result per pop
//  cfg     | cfg_we_i / cfg_index_i / cfg_data_i  | register write, no wait
//
//  a pop reads the queue ram in ST_POP_RD, then ST_POP_OUT waits on the output register
//  a push examines each held byte as a read of the holding ram in a _RD state,
//    then a state that uses the data (_CHK or _ACC); a rejection rescans from
//    the next byte
//  reset clears pointers, counts, flags and config; ram contents stay undefined
//  in_ready_o is low while a scan or pop runs; out stalls hold the result
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer #(
  parameter int unsigned HOLD_DEPTH  = 1024,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccfd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccfd_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned AW  = $clog2(HOLD_DEPTH);
  localparam int unsigned CW  = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QFW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_SOF_RD    = 12'b000000000010,
    ST_SOF_CHK   = 12'b000000000100,
    ST_HDR_RD    = 12'b000000001000,
    ST_HDR_ACC   = 12'b000000010000,
    ST_HDR_EVAL  = 12'b000000100000,
    ST_BODY_RD   = 12'b000001000000,
    ST_BODY_ACC  = 12'b000010000000,
    ST_BODY_EVAL = 12'b000100000000,
    ST_ENQ       = 12'b001000000000,
    ST_POP_RD    = 12'b010000000000,
    ST_POP_OUT   = 12'b100000000000
  } state_e;

  function automatic logic [AW-1:0] hold_wrap(logic [AW:0] s);
    logic [AW:0] t;
    t = s - (AW+1)'(HOLD_DEPTH);
    return (s >= (AW+1)'(HOLD_DEPTH)) ? t[AW-1:0] : s[AW-1:0];
  endfunction

  function automatic logic [QAW-1:0] queue_wrap(logic [QAW:0] s);
    logic [QAW:0] t;
    t = s - (QAW+1)'(QUEUE_DEPTH);
    return (s >= (QAW+1)'(QUEUE_DEPTH)) ? t[QAW-1:0] : s[QAW-1:0];
  endfunction

  // configuration
  logic        crc_en_q;
  logic [7:0]  hdr_seed_q;
  logic [15:0] frm_seed_q;

  // control state
  state_e         state_q, state_d;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QFW-1:0] fill_q, fill_d;
  logic           ovf_q, ovf_d;
  logic           out_valid_q, out_valid_d;

  // payload state
  logic [7:0]          hdr_q [1:ccfd_pkg::HdrLast];
  logic [7:0]          hdr_d [1:ccfd_pkg::HdrLast];
  logic [7:0]          crc8_q, crc8_d;
  logic [15:0]         crc16_q, crc16_d;
  logic [7:0]          tail_lo_q, tail_lo_d;
  logic [7:0]          tail_hi_q, tail_hi_d;
  ccfd_pkg::out_item_t out_q, out_d;

  // memories
  logic [7:0]      hold_mem [HOLD_DEPTH];
  logic [7:0]      hold_rdata_q;
  ccfd_pkg::desc_t queue_mem [QUEUE_DEPTH];
  ccfd_pkg::desc_t queue_rdata_q;

  logic            in_xfer;
  logic            hold_we, hold_re;
  logic [AW-1:0]   hold_waddr, hold_raddr;
  logic            queue_we, queue_re;
  logic [QAW-1:0]  queue_waddr;
  ccfd_pkg::desc_t queue_wdata;

  logic [9:0]    frame_len;
  logic [AW-1:0] len_ext;
  logic [AW-1:0] head_plus1;
  logic [CW-1:0] count_m1;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign frame_len  = {hdr_q[2][1:0], hdr_q[1]};
  assign len_ext    = AW'(frame_len);
  assign head_plus1 = hold_wrap({1'b0, head_q} + (AW+1)'(1));
  assign count_m1   = count_q - CW'(1);

  // holding ram: write at the tail on push, read at head + idx during a scan
  assign hold_we    = in_xfer && (in_data_i.req_type == ccfd_pkg::ReqPush);
  assign hold_waddr = hold_wrap({1'b0, head_q} + (AW+1)'(count_q));
  assign hold_re    = (state_q == ST_SOF_RD) || (state_q == ST_HDR_RD) ||
                      (state_q == ST_BODY_RD);
  assign hold_raddr = hold_wrap({1'b0, head_q} + {1'b0, idx_q});

  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_mem[hold_waddr] <= in_data_i.rx_byte;
    end
    if (hold_re) begin
      hold_rdata_q <= hold_mem[hold_raddr];
    end
  end

  // descriptor queue ram
  assign queue_re    = (state_q == ST_POP_RD);
  assign queue_waddr = queue_wrap({1'b0, rd_ptr_q} + (QAW+1)'(fill_q));
  always_comb begin
    queue_wdata                  = '0;
    queue_wdata.frame_length     = frame_len;
    queue_wdata.protocol_version = hdr_q[2][7:2];
    queue_wdata.sender_id        = hdr_q[4][4:0];
    queue_wdata.sender_index     = hdr_q[4][7:5];
    queue_wdata.receiver_id      = hdr_q[5][4:0];
    queue_wdata.receiver_index   = hdr_q[5][7:5];
    queue_wdata.sequence_number  = {hdr_q[7], hdr_q[6]};
    queue_wdata.frame_flags      = hdr_q[8];
    queue_wdata.command_set      = hdr_q[9];
    queue_wdata.command_id       = hdr_q[10];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    if (queue_re) begin
      queue_rdata_q <= queue_mem[rd_ptr_q];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q   <= ccfd_pkg::CrcEnableReset;
      hdr_seed_q <= ccfd_pkg::HeaderSeedReset;
      frm_seed_q <= ccfd_pkg::FrameSeedReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ccfd_pkg::CfgCrcEnable:  crc_en_q   <= cfg_data_i[0];
        ccfd_pkg::CfgHeaderSeed: hdr_seed_q <= cfg_data_i[7:0];
        ccfd_pkg::CfgFrameSeed:  frm_seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan and pop sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    hdr_d       = hdr_q;
    crc8_d      = crc8_q;
    crc16_d     = crc16_q;
    tail_lo_d   = tail_lo_q;
    tail_hi_d   = tail_hi_q;
    out_d       = out_q;
    queue_we    = 1'b0;

    // result leaves the output register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.req_type == ccfd_pkg::ReqPush) begin
            // full buffer: the new byte overwrites the oldest one
            if (count_q == CW'(HOLD_DEPTH)) begin
              head_d = head_plus1;
            end else begin
              count_d = count_q + CW'(1);
            end
            idx_d   = '0;
            state_d = ST_SOF_RD;
          end else begin
            state_d = ST_POP_RD;
          end
        end
      end
      ST_SOF_RD: begin
        idx_d   = '0;
        state_d = (count_q == '0) ? ST_IDLE : ST_SOF_CHK;
      end
      ST_SOF_CHK: begin
        if (hold_rdata_q != ccfd_pkg::SofByte) begin
          head_d  = head_plus1;
          count_d = count_m1;
          state_d = ST_SOF_RD;
        end else if (count_q < CW'(ccfd_pkg::MinFrame)) begin
          state_d = ST_IDLE;
        end else begin
          crc8_d  = hdr_seed_q;
          crc16_d = frm_seed_q;
          state_d = ST_HDR_RD;
        end
      end
      ST_HDR_RD: begin
        state_d = ST_HDR_ACC;
      end
      ST_HDR_ACC: begin
        // header bytes all lie inside the crc-16 span
        if (idx_q < AW'(3)) begin
          crc8_d = ccfd_pkg::crc8_byte(crc8_q, hold_rdata_q);
        end
        crc16_d = ccfd_pkg::crc16_byte(crc16_q, hold_rdata_q);
        for (int k = 1; k <= ccfd_pkg::HdrLast; k++) begin
          if (idx_q == AW'(k)) begin
            hdr_d[k] = hold_rdata_q;
          end
        end
        if (idx_q == AW'(ccfd_pkg::HdrLast)) begin
          state_d = ST_HDR_EVAL;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_HDR_RD;
        end
      end
      ST_HDR_EVAL: begin
        if ((crc_en_q && (crc8_q != hdr_q[3])) || (frame_len < ccfd_pkg::MinFrame)) begin
          head_d  = head_plus1;
          count_d = count_m1;
          idx_d   = '0;
          state_d = ST_SOF_RD;
        end else if (CW'(frame_len) > count_q) begin
          state_d = ST_IDLE;
        end else if (!crc_en_q) begin
          state_d = ST_ENQ;
        end else begin
          idx_d   = AW'(ccfd_pkg::HdrLast + 1);
          state_d = ST_BODY_RD;
        end
      end
      ST_BODY_RD: begin
        state_d = ST_BODY_ACC;
      end
      ST_BODY_ACC: begin
        if (idx_q < len_ext - AW'(2)) begin
          crc16_d = ccfd_pkg::crc16_byte(crc16_q, hold_rdata_q);
        end else if (idx_q == len_ext - AW'(2)) begin
          tail_lo_d = hold_rdata_q;
        end else begin
          tail_hi_d = hold_rdata_q;
        end
        if (idx_q == len_ext - AW'(1)) begin
          state_d = ST_BODY_EVAL;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_BODY_RD;
        end
      end
      ST_BODY_EVAL: begin
        if (crc16_q != {tail_hi_q, tail_lo_q}) begin
          head_d  = head_plus1;
          count_d = count_m1;
          idx_d   = '0;
          state_d = ST_SOF_RD;
        end else begin
          state_d = ST_ENQ;
        end
      end
      ST_ENQ: begin
        // queue full: frame still leaves the buffer, flag sticks
        if (fill_q == QFW'(QUEUE_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          queue_we = 1'b1;
          fill_d   = fill_q + QFW'(1);
        end
        head_d  = hold_wrap({1'b0, head_q} + {1'b0, len_ext});
        count_d = count_q - CW'(frame_len);
        idx_d   = '0;
        state_d = ST_SOF_RD;
      end
      ST_POP_RD: begin
        state_d = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = '0;
          if (fill_q != '0) begin
            out_d.frame_valid      = 1'b1;
            out_d.frame_length     = queue_rdata_q.frame_length;
            out_d.protocol_version = queue_rdata_q.protocol_version;
            out_d.sender_id        = queue_rdata_q.sender_id;
            out_d.sender_index     = queue_rdata_q.sender_index;
            out_d.receiver_id      = queue_rdata_q.receiver_id;
            out_d.receiver_index   = queue_rdata_q.receiver_index;
            out_d.sequence_number  = queue_rdata_q.sequence_number;
            out_d.frame_flags      = queue_rdata_q.frame_flags;
            out_d.command_set      = queue_rdata_q.command_set;
            out_d.command_id       = queue_rdata_q.command_id;
            rd_ptr_d = queue_wrap({1'b0, rd_ptr_q} + (QAW+1)'(1));
            fill_d   = fill_q - QFW'(1);
          end
          out_d.queue_overflowed = ovf_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q     <= hdr_d;
    crc8_q    <= crc8_d;
    crc16_q   <= crc16_d;
    tail_lo_q <= tail_lo_d;
    tail_hi_q <= tail_hi_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HOLD_DEPTH))
    else $error("held byte count above buffer depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QFW'(QUEUE_DEPTH))
    else $error("queue fill above queue depth");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_valid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_valid) |->
      (out_data_o.frame_length >= ccfd_pkg::MinFrame))
    else $error("returned frame shorter than minimum");

endmodule
